// ===== sv/nearest_texture_sampler_assert.svh =====
// Assertion helpers shared by the sampler's modules.
`ifndef NEAREST_TEXTURE_SAMPLER_ASSERT_SVH
`define NEAREST_TEXTURE_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define NTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== sv/nts_pkg.sv =====
package nts_pkg;

  localparam int COORD_W   = 24;
  localparam int COLOR_W   = 32;
  localparam int UV_W      = 8;
  localparam int SIZE_W    = 9;
  localparam int Q_W       = 10;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // Result slots: cover the pipeline so the input stays open while the consumer keeps up.
  localparam int OUT_DEPTH = 16;

  localparam logic [SIZE_W-1:0] DEF_SIZE = SIZE_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MIRROR = 2'd2
  } cfg_reg_e;

  // Memory access issued by the address pipeline.
  typedef struct packed {
    logic we;
    logic rsp;
    logic oor;
  } mem_ctl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] texel;
    logic               oor;
  } rsp_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ===== sv/nts_req_if.sv =====
interface nts_req_if;
  logic                              valid;
  logic                              ready;
  nts_pkg::cmd_e                     cmd;
  logic [nts_pkg::UV_W-1:0]          texel_u;
  logic [nts_pkg::UV_W-1:0]          texel_v;
  logic [nts_pkg::COLOR_W-1:0]       texel_color;
  logic signed [nts_pkg::COORD_W-1:0] coord_s;
  logic signed [nts_pkg::COORD_W-1:0] coord_t;

  modport source (output valid, cmd, texel_u, texel_v, texel_color, coord_s, coord_t,
                  input ready);
  modport sink (input valid, cmd, texel_u, texel_v, texel_color, coord_s, coord_t,
                output ready);
endinterface

// ===== sv/nts_rsp_if.sv =====
interface nts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nts_pkg::COLOR_W-1:0] texel_out;
  logic                        out_of_range;

  modport source (output valid, texel_out, out_of_range, input ready);
  modport sink (input valid, texel_out, out_of_range, output ready);
endinterface

// ===== sv/nts_cfg_if.sv =====
interface nts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nts_pkg::CFG_IDX_W-1:0] addr;
  logic [nts_pkg::SIZE_W-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== sv/nts_ram.sv =====
module nts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/nts_coord.sv =====
module nts_coord #(
  parameter int MAX_WIDTH       = nts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = nts_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = nts_pkg::DEF_FRAC_BITS,
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  nts_pkg::cmd_e                      cmd,
  input  logic [nts_pkg::UV_W-1:0]           texel_u,
  input  logic [nts_pkg::UV_W-1:0]           texel_v,
  input  logic [nts_pkg::COLOR_W-1:0]        texel_color,
  input  logic signed [nts_pkg::COORD_W-1:0] coord_s,
  input  logic signed [nts_pkg::COORD_W-1:0] coord_t,
  input  logic [nts_pkg::SIZE_W-1:0]         tex_width,
  input  logic [nts_pkg::SIZE_W-1:0]         tex_height,
  input  logic                               mirror_tile,
  output nts_pkg::mem_ctl_t                  ctl,
  output logic [ADDR_W-1:0]                  addr,
  output logic [nts_pkg::COLOR_W-1:0]        wdata
);
  import nts_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int MAG_W  = COORD_W + 1;
  localparam int FM_W   = F + 1;
  localparam int PROD_W = FM_W + SIZE_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam logic [FM_W-1:0] ONE = FM_W'(1) << F;

  // Axis 0 is horizontal (s, u, width), axis 1 is vertical (t, v, height).
  logic [F-1:0]          frac_in [2];
  logic                  neg_in  [2];
  logic                  odd_in  [2];

  logic                  s1_valid;
  cmd_e                  s1_cmd;
  logic [UV_W-1:0]       s1_uv   [2];
  logic [COLOR_W-1:0]    s1_color;
  logic [F-1:0]          s1_frac [2];
  logic                  s1_neg  [2];
  logic                  s1_odd  [2];

  logic [FM_W-1:0]       fm_next   [2];
  logic                  fneg_next [2];
  logic                  s2_valid;
  cmd_e                  s2_cmd;
  logic [UV_W-1:0]       s2_uv   [2];
  logic [COLOR_W-1:0]    s2_color;
  logic [FM_W-1:0]       s2_fm   [2];
  logic                  s2_fneg [2];

  logic [SIZE_W-1:0]     size    [2];
  logic [Q_W-1:0]        q_next  [2];
  logic                  s3_valid;
  cmd_e                  s3_cmd;
  logic [COLOR_W-1:0]    s3_color;
  logic [Q_W-1:0]        s3_q    [2];
  logic                  s3_neg  [2];

  logic                  oor_next;
  logic [Q_W-1:0]        row_full;
  logic                  s4_valid;
  cmd_e                  s4_cmd;
  logic [COLOR_W-1:0]    s4_color;
  logic                  s4_oor;
  logic [COL_W-1:0]      s4_col;
  logic [ROW_W-1:0]      s4_row;

  logic [ROW_W+SIZE_W-1:0] row_base;

  assign size[0] = tex_width;
  assign size[1] = tex_height;

  // Split each coordinate into sign, parity of the integer part and the fraction
  // magnitude; truncation toward zero leaves the fraction with the sign of c.
  always_comb begin
    logic signed [COORD_W-1:0] c;
    logic [MAG_W-1:0]          mag;
    for (int a = 0; a < 2; a++) begin
      c = (a == 0) ? coord_s : coord_t;
      neg_in[a] = c[COORD_W-1];
      mag = neg_in[a] ? (MAG_W'(0) - {c[COORD_W-1], c}) : {1'b0, c};
      odd_in[a]  = mag[F];
      frac_in[a] = mag[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (cmd != CMD_NOP);
    end
    s1_cmd   <= cmd;
    s1_uv[0] <= texel_u;
    s1_uv[1] <= texel_v;
    s1_color <= texel_color;
    for (int a = 0; a < 2; a++) begin
      s1_frac[a] <= frac_in[a];
      s1_neg[a]  <= neg_in[a];
      s1_odd[a]  <= odd_in[a];
    end
  end

  // Mirrored odd tiles use 1 - f, which is never negative.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (mirror_tile && s1_odd[a]) begin
        fm_next[a]   = (s1_neg[a] && (s1_frac[a] != '0)) ? ONE + FM_W'(s1_frac[a])
                                                         : ONE - FM_W'(s1_frac[a]);
        fneg_next[a] = 1'b0;
      end else begin
        fm_next[a]   = FM_W'(s1_frac[a]);
        fneg_next[a] = s1_neg[a] && (s1_frac[a] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_cmd   <= s1_cmd;
    s2_color <= s1_color;
    for (int a = 0; a < 2; a++) begin
      s2_uv[a]   <= s1_uv[a];
      s2_fm[a]   <= fm_next[a];
      s2_fneg[a] <= fneg_next[a];
    end
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int a = 0; a < 2; a++) begin
      prod = PROD_W'(s2_fm[a]) * PROD_W'(size[a]);
      q_next[a] = (s2_cmd == CMD_SAMPLE) ? Q_W'(prod >> F) : Q_W'(s2_uv[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_cmd   <= s2_cmd;
    s3_color <= s2_color;
    for (int a = 0; a < 2; a++) begin
      s3_q[a]   <= q_next[a];
      s3_neg[a] <= (s2_cmd == CMD_SAMPLE) && s2_fneg[a];
    end
  end

  // A negative index shows up as a nonzero quotient with the sign flag set.
  always_comb begin
    oor_next = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if ((s3_neg[a] && (s3_q[a] != '0)) || (s3_q[a] >= Q_W'(size[a]))) begin
        oor_next = 1'b1;
      end
    end
    row_full = Q_W'(tex_height) - s3_q[1] - Q_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_cmd   <= s3_cmd;
    s4_color <= s3_color;
    s4_oor   <= oor_next;
    s4_col   <= oor_next ? '0 : COL_W'(s3_q[0]);
    s4_row   <= oor_next ? '0 : ROW_W'(row_full);
  end

  assign row_base = (ROW_W+SIZE_W)'(s4_row) * (ROW_W+SIZE_W)'(tex_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.we  <= s4_valid && (s4_cmd == CMD_WRITE) && !s4_oor;
      ctl.rsp <= s4_valid && (s4_cmd != CMD_WRITE);
      ctl.oor <= s4_oor;
    end
    addr  <= ADDR_W'(row_base) + ADDR_W'(s4_col);
    wdata <= s4_color;
  end

endmodule

// ===== sv/nts_ofifo.sv =====
`include "nearest_texture_sampler_assert.svh"

module nts_ofifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nts_pkg::rsp_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output nts_pkg::rsp_t pop_data
);
  import nts_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  rsp_t             slots [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `NTS_ASSERT_NOW(a_no_overflow, clk, rst, push, count != CNT_W'(OUT_DEPTH))
  `NTS_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))
  `NTS_ASSERT_NEXT(a_pop_shrinks, clk, rst, pop && !push, count == $past(count) - CNT_W'(1))

endmodule

// ===== sv/nearest_texture_sampler.sv =====
// Nearest-neighbor texture sampler. Takes one item per clock while the output
// queue has room: writes, integer reads and fixed-point samples with repeat or
// mirrored tiling all flow down the same five-stage address pipeline
// (coordinate split, mirror, scale by the texture size, range check,
// row-flipped address multiply) into one single-port texel RAM, so memory
// accesses happen in item order and no forwarding is needed. A read or sample
// result enters the output queue after the registered RAM read and can be
// taken once the queue has stored it; up to sixteen results may be
// outstanding, which keeps the input open every cycle while the consumer keeps
// up. The texel RAM is not cleared at reset, and a word that was never written
// reads back as whatever the RAM holds. Configuration writes take effect at
// once and belong between items, when the pipeline has drained.
`include "nearest_texture_sampler_assert.svh"

module nearest_texture_sampler #(
  parameter int MAX_WIDTH       = nts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = nts_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = nts_pkg::DEF_FRAC_BITS
) (
  input logic       clk,
  input logic       rst,
  nts_req_if.sink   req,
  nts_rsp_if.source rsp,
  nts_cfg_if.sink   cfg
);
  import nts_pkg::*;

  localparam int MEM_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

  logic [SIZE_W-1:0]  tex_width;
  logic [SIZE_W-1:0]  tex_height;
  logic               mirror_tile;

  logic               accept;
  mem_ctl_t           ctl;
  logic [ADDR_W-1:0]  mem_addr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] mem_rdata;

  logic               rd_valid;
  logic               rd_oor;
  rsp_t               push_data;
  rsp_t               pop_data;

  logic [PEND_W-1:0]  pending;
  logic [PEND_W-1:0]  pending_next;
  logic               takes_slot;
  logic               out_taken;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= clamp_size(DEF_SIZE, MAX_WIDTH);
      tex_height  <= clamp_size(DEF_SIZE, MAX_HEIGHT);
      mirror_tile <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_WIDTH:  tex_width   <= clamp_size(cfg.data, MAX_WIDTH);
        REG_HEIGHT: tex_height  <= clamp_size(cfg.data, MAX_HEIGHT);
        REG_MIRROR: mirror_tile <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Every read or sample holds a queue slot from acceptance until delivery.
  assign req.ready    = !rst && (pending < PEND_W'(OUT_DEPTH));
  assign accept       = req.valid && req.ready;
  assign takes_slot   = accept && ((req.cmd == CMD_READ) || (req.cmd == CMD_SAMPLE));
  assign out_taken    = rsp.valid && rsp.ready;
  assign pending_next = pending + PEND_W'(takes_slot) - PEND_W'(out_taken);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  nts_coord #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_coord (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (req.cmd),
    .texel_u     (req.texel_u),
    .texel_v     (req.texel_v),
    .texel_color (req.texel_color),
    .coord_s     (req.coord_s),
    .coord_t     (req.coord_t),
    .tex_width   (tex_width),
    .tex_height  (tex_height),
    .mirror_tile (mirror_tile),
    .ctl         (ctl),
    .addr        (mem_addr),
    .wdata       (mem_wdata)
  );

  nts_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MEM_WORDS)
  ) u_texels (
    .clk   (clk),
    .we    (ctl.we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctl.rsp;
    end
    rd_oor <= ctl.oor;
  end

  assign push_data.texel = mem_rdata;
  assign push_data.oor   = rd_oor;

  nts_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_data (push_data),
    .pop_valid (rsp.valid),
    .pop_ready (rsp.ready),
    .pop_data  (pop_data)
  );

  assign rsp.texel_out    = pop_data.texel;
  assign rsp.out_of_range = pop_data.oor;

  `NTS_ASSERT_NOW(a_pending_bound, clk, rst, 1'b1, pending <= PEND_W'(OUT_DEPTH))
  `NTS_ASSERT_NOW(a_write_no_result, clk, rst, ctl.we, !ctl.rsp && !ctl.oor)
  `NTS_ASSERT_NOW(a_oor_word_zero, clk, rst, ctl.rsp && ctl.oor, mem_addr == '0)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nts_pkg::*;

  localparam longint FRAC_ONE = longint'(1) << DEF_FRAC_BITS;
  localparam int TEX_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  // Give writes and no-ops room to retire.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    cmd_e                      cmd;
    logic [UV_W-1:0]           u;
    logic [UV_W-1:0]           v;
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] s;
    logic signed [COORD_W-1:0] t;
  } tex_req_t;

  typedef struct {
    logic [COLOR_W-1:0] texel;
    logic               oor;
  } fetch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nts_req_if req_ch();
  nts_rsp_if rsp_ch();
  nts_cfg_if cfg_ch();

  nearest_texture_sampler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  int tex_w = DEF_MAX_WIDTH;
  int tex_h = DEF_MAX_HEIGHT;
  bit tex_mirror = 1'b0;

  logic [COLOR_W-1:0] texel_store [TEX_WORDS];
  bit                 word_written [TEX_WORDS];

  tex_req_t pending_req_q[$];
  tex_req_t cur_req;
  fetch_t   fetch_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;

  function automatic int tile_index(logic signed [COORD_W-1:0] c, int n);
    longint cv, ip, f;
    cv = c;
    ip = cv / FRAC_ONE;
    f = cv - ip * FRAC_ONE;
    if (tex_mirror && (ip % 2) != 0) f = FRAC_ONE - f;
    return int'((f * n) / FRAC_ONE);
  endfunction

  // Finds the texel an item addresses. Outside the texture the address is word 0.
  function automatic bit locate_texel(tex_req_t it, output int tu, output int tv,
                                      output int addr);
    if (it.cmd == CMD_SAMPLE) begin
      tu = tile_index(it.s, tex_w);
      tv = tile_index(it.t, tex_h);
    end else begin
      tu = int'(it.u);
      tv = int'(it.v);
    end
    addr = 0;
    if (tu < 0 || tu >= tex_w || tv < 0 || tv >= tex_h) return 1'b0;
    addr = (tex_h - 1 - tv) * tex_w + tu;
    return 1'b1;
  endfunction

  function automatic void predict_fetch(tex_req_t it);
    int tu, tv, addr;
    fetch_t r;
    case (it.cmd)
      CMD_WRITE: begin
        if (locate_texel(it, tu, tv, addr)) texel_store[addr] = it.color;
      end
      CMD_READ, CMD_SAMPLE: begin
        r.oor = !locate_texel(it, tu, tv, addr);
        r.texel = texel_store[addr];
        fetch_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // A fetch of a word that was never stored gets a write of that texel ahead of it.
  function automatic void queue_request(tex_req_t it);
    int tu, tv, addr;
    tex_req_t fill;
    if (it.cmd != CMD_NOP && locate_texel(it, tu, tv, addr) && !word_written[addr]) begin
      if (it.cmd != CMD_WRITE) begin
        fill = it;
        fill.cmd = CMD_WRITE;
        fill.u = UV_W'(tu);
        fill.v = UV_W'(tv);
        fill.color = $urandom;
        pending_req_q.push_back(fill);
      end
      word_written[addr] = 1'b1;
    end
    pending_req_q.push_back(it);
  endfunction

  function automatic tex_req_t make_req(cmd_e c, int u, int v, logic [COLOR_W-1:0] color,
                                        logic [COORD_W-1:0] s, logic [COORD_W-1:0] t);
    tex_req_t it;
    it.cmd = c;
    it.u = UV_W'(u);
    it.v = UV_W'(v);
    it.color = color;
    it.s = s;
    it.t = t;
    return it;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    longint c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = $urandom_range(5 << DEF_FRAC_BITS);
      2: c = longint'($urandom_range(6)) * FRAC_ONE + longint'($urandom_range(2)) - 1;
      default: c = $urandom_range(2000);
    endcase
    if ($urandom_range(1)) c = -c;
    return COORD_W'(c);
  endfunction

  function automatic tex_req_t random_request();
    tex_req_t it;
    int pick;
    pick = $urandom_range(99);
    it.u = UV_W'($urandom);
    it.v = UV_W'($urandom);
    it.color = $urandom;
    it.s = random_coord();
    it.t = random_coord();
    if (pick < 5) it.cmd = CMD_NOP;
    else if (pick < 25) it.cmd = CMD_WRITE;
    else if (pick < 50) it.cmd = CMD_READ;
    else it.cmd = CMD_SAMPLE;
    // Most integer accesses land inside the texture; the rest probe the bounds.
    if (it.cmd != CMD_SAMPLE && $urandom_range(9) < 8) begin
      it.u = UV_W'($urandom_range(tex_w - 1));
      it.v = UV_W'($urandom_range(tex_h - 1));
    end
    return it;
  endfunction

  function automatic int clip_dim(logic [SIZE_W-1:0] raw, int maxv);
    return (raw == '0) ? 1 : ((int'(raw) < maxv) ? int'(raw) : maxv);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WIDTH:  tex_w = clip_dim(value, DEF_MAX_WIDTH);
      REG_HEIGHT: tex_h = clip_dim(value, DEF_MAX_HEIGHT);
      REG_MIRROR: tex_mirror = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_req_q.size() != 0 || req_ch.valid || fetch_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  task automatic run_phase(int n, int mode);
    @(negedge clk);
    set_idling(mode);
    repeat (n) queue_request(random_request());
    wait_drained();
  endtask

  // Request driver: predicts each item as it is accepted, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) predict_fetch(cur_req);
      if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_req_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cur_req.cmd;
        req_ch.texel_u <= cur_req.u;
        req_ch.texel_v <= cur_req.v;
        req_ch.texel_color <= cur_req.color;
        req_ch.coord_s <= cur_req.s;
        req_ch.coord_t <= cur_req.t;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready, with an occasional long hold that lets the block back up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    fetch_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (fetch_q.size() == 0) begin
        $error("result item with no fetch pending: texel_out %h", rsp_ch.texel_out);
        err_count++;
      end else begin
        exp_r = fetch_q.pop_front();
        if (rsp_ch.texel_out !== exp_r.texel) begin
          $error("texel_out: expected %h, got %h", exp_r.texel, rsp_ch.texel_out);
          err_count++;
        end
        if (rsp_ch.out_of_range !== exp_r.oor) begin
          $error("out_of_range: expected %0b, got %0b", exp_r.oor, rsp_ch.out_of_range);
          err_count++;
        end
      end
    end
  end

  initial begin
    tex_req_t it;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_NOP;
    req_ch.texel_u = '0;
    req_ch.texel_v = '0;
    req_ch.texel_color = '0;
    req_ch.coord_s = '0;
    req_ch.coord_t = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_WIDTH;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Full-size texture: corner texels, color extremes, coordinate extremes.
    @(negedge clk);
    queue_request(make_req(CMD_WRITE, 0, 255, 32'h5A5A_C3C3, '0, '0));
    queue_request(make_req(CMD_WRITE, 255, 0, 32'hFFFF_FFFF, '0, '0));
    queue_request(make_req(CMD_WRITE, 255, 255, 32'h0000_0000, '0, '0));
    queue_request(make_req(CMD_READ, 0, 255, '0, '0, '0));
    queue_request(make_req(CMD_READ, 255, 0, '0, '0, '0));
    queue_request(make_req(CMD_READ, 255, 255, '0, '0, '0));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'h7FFFFF, 24'h800000));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'hFFFFFF, 24'hFFFFFF));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'hFF8000, 24'h000000));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'h030000, 24'h010000));
    queue_request(make_req(CMD_NOP, 0, 0, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF));
    wait_drained();

    // Small mirrored texture: bounds on writes and reads, odd and negative tiles.
    write_reg(REG_WIDTH, 9'd16);
    write_reg(REG_HEIGHT, 9'd8);
    write_reg(REG_MIRROR, 9'd1);
    write_reg(REG_UNUSED, 9'h1FF);
    @(negedge clk);
    queue_request(make_req(CMD_WRITE, 20, 3, 32'h1234_5678, '0, '0));
    queue_request(make_req(CMD_WRITE, 3, 20, 32'h8765_4321, '0, '0));
    queue_request(make_req(CMD_READ, 20, 3, '0, '0, '0));
    queue_request(make_req(CMD_WRITE, 15, 7, 32'hFFFF_FFFF, '0, '0));
    queue_request(make_req(CMD_READ, 15, 7, '0, '0, '0));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'h018000, 24'h010000));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'hFEC000, 24'h000000));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'h02C000, 24'h034000));
    queue_request(make_req(CMD_SAMPLE, 0, 0, '0, 24'hFFFFFF, 24'hFFFF00));
    wait_drained();

    for (int p = 0; p < 13; p++) begin
      case (p)
        0: begin write_reg(REG_WIDTH, 9'd256); write_reg(REG_HEIGHT, 9'd256);
                 write_reg(REG_MIRROR, 9'd1); end
        1: begin write_reg(REG_WIDTH, 9'd1); write_reg(REG_HEIGHT, 9'd1);
                 write_reg(REG_MIRROR, 9'd0); end
        2: write_reg(REG_MIRROR, 9'd1);
        3: begin write_reg(REG_WIDTH, 9'd0); write_reg(REG_HEIGHT, 9'h1FF);
                 write_reg(REG_MIRROR, 9'd0); end
        4: begin write_reg(REG_WIDTH, 9'd256); write_reg(REG_HEIGHT, 9'd1);
                 write_reg(REG_MIRROR, 9'd1); end
        5: begin write_reg(REG_WIDTH, 9'h1FF); write_reg(REG_HEIGHT, 9'd0);
                 write_reg(REG_MIRROR, 9'd0); end
        default: begin
          write_reg(REG_WIDTH, SIZE_W'($urandom));
          write_reg(REG_HEIGHT, SIZE_W'($urandom));
          write_reg(REG_MIRROR, SIZE_W'($urandom));
        end
      endcase
      run_phase(100, p % 4);

      if (p == 6) begin
        // Fetch burst, with fill writes where needed, and the receiver held off so the result slots fill.
        @(negedge clk);
        set_idling(0);
        repeat (90) begin
          it = random_request();
          if (it.cmd == CMD_WRITE || it.cmd == CMD_NOP) it.cmd = CMD_SAMPLE;
          queue_request(it);
        end
        @(posedge clk);
        hold_left <= HOLD_CYCLES;
        wait_drained();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && fetch_q.size() == 0) begin
      $display("[nearest_texture_sampler] OK");
    end else begin
      $display("[nearest_texture_sampler] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[nearest_texture_sampler] ERROR");
    $finish;
  end

endmodule
